[sv/mks_pkg.sv]
// ----------------------------------------------------------------------------
// mks_pkg: shared types and constants for the matrix keypad scanner
// Payload structs of the sample and result channels, register indexes and
// reset values of the configuration registers, and the debounce counter width.
// ----------------------------------------------------------------------------
package mks_pkg;

	// Width of the debounce counter (8 to 32)
	localparam int COUNT_WIDTH = 16;

	// Row and column line levels
	localparam logic [3:0] ALL_HIGH = 4'hF;
	localparam logic [3:0] ALL_LOW  = 4'h0;

	// Configuration register indexes
	localparam logic [2:0] REG_ROW0_KEYS      = 3'd0;
	localparam logic [2:0] REG_ROW1_KEYS      = 3'd1;
	localparam logic [2:0] REG_ROW2_KEYS      = 3'd2;
	localparam logic [2:0] REG_ROW3_KEYS      = 3'd3;
	localparam logic [2:0] REG_DEBOUNCE_TICKS = 3'd4;

	// Configuration reset values
	localparam logic [31:0] RESET_ROW0_KEYS = 32'd1093874225;
	localparam logic [31:0] RESET_ROW1_KEYS = 32'd1110848820;
	localparam logic [31:0] RESET_ROW2_KEYS = 32'd758724663;
	localparam logic [31:0] RESET_ROW3_KEYS = 32'd1111306282;
	localparam logic [15:0] RESET_DEBOUNCE  = 16'd100;

	// One sample request
	typedef struct packed {
		logic [3:0] column_sense;
		logic       abort;
	} mks_in_t;

	// One result request
	typedef struct packed {
		logic [3:0] row_drive;
		logic       key_valid;
		logic [7:0] key_code;
		logic       aborted;
	} mks_out_t;

endpackage

[sv/matrix_keypad_scanner_core.sv]
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_core: 4x4 active-low matrix keypad scanner
// One column sample in, one result out: row drive, key strobe and abort strobe.
// ----------------------------------------------------------------------------
// Each accepted sample produces exactly one result in the next cycle. A new sample
// is taken in every cycle, held back only while the result register is full and
// the result side stalls; the scan state machine advances once per sample. The
// column sample is expected to reflect the row drive of the previous result.
// While idle all rows are driven low; a low column starts a probe of one row at
// a time from row 0, the lowest low column of the first hit row selects a byte
// of that row's key map, and the key is reported after release plus
// debounce_ticks samples. Abort is honored only while idle. Configuration is
// written through cfg_wr_en/cfg_index/cfg_data; unknown indexes are ignored.
module matrix_keypad_scanner_core
	import mks_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// sample channel
	input  logic        sample_valid,
	output logic        sample_stall,
	input  mks_in_t     sample,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output mks_out_t    result,
	// configuration write port
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_PROBE   = 2'd1;
	localparam logic [1:0] PH_RELEASE = 2'd2;
	localparam logic [1:0] PH_SETTLE  = 2'd3;

	localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

	// configuration registers
	logic [31:0] row_keys_q [4];
	logic [15:0] debounce_ticks_q;

	// scan state
	logic [1:0]             phase_q;
	logic [1:0]             probe_row_q;
	logic [7:0]             held_code_q;
	logic [COUNT_WIDTH-1:0] settle_count_q;

	// result register
	logic     result_valid_q;
	mks_out_t result_q;

	logic accept;

	// next-state and result logic
	logic [1:0]             phase_d;
	logic [1:0]             probe_row_d;
	logic [7:0]             held_code_d;
	logic [COUNT_WIDTH-1:0] settle_count_d;
	mks_out_t               result_d;

	logic [1:0]             low_col;
	logic [31:0]            row_map;
	logic [32:0]            load;
	logic [COUNT_WIDTH-1:0] count_dec;
	logic                   report;

	// Take a sample whenever the result register is free or being drained
	assign sample_stall = result_valid_q && result_stall;
	assign accept       = sample_valid && !sample_stall;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Lowest low column of the sample
	always_comb begin
		if (!sample.column_sense[0]) begin
			low_col = 2'd0;
		end else if (!sample.column_sense[1]) begin
			low_col = 2'd1;
		end else if (!sample.column_sense[2]) begin
			low_col = 2'd2;
		end else begin
			low_col = 2'd3;
		end
	end

	assign row_map = row_keys_q[probe_row_q];

	// Saturate the debounce load to the counter width
	always_comb begin
		load = {17'd0, debounce_ticks_q};
		if (load > COUNT_MAX) begin
			load = COUNT_MAX;
		end
	end

	assign count_dec = (settle_count_q != '0) ? settle_count_q - 1'b1 : settle_count_q;

	// Advance the scan by one sample
	always_comb begin
		phase_d            = phase_q;
		probe_row_d        = probe_row_q;
		held_code_d        = held_code_q;
		settle_count_d     = settle_count_q;
		result_d.row_drive = ALL_LOW;
		result_d.key_valid = 1'b0;
		result_d.key_code  = 8'd0;
		result_d.aborted   = 1'b0;
		report             = 1'b0;

		case (phase_q)
			PH_IDLE: begin
				if (sample.abort) begin
					result_d.aborted = 1'b1;
				end else if (sample.column_sense != ALL_HIGH) begin
					phase_d            = PH_PROBE;
					probe_row_d        = 2'd0;
					result_d.row_drive = 4'b1110;
				end
			end
			PH_PROBE: begin
				if (sample.column_sense != ALL_HIGH) begin
					held_code_d = row_map[{low_col, 3'b000} +: 8];
					phase_d     = PH_RELEASE;
				end else if (probe_row_q == 2'd3) begin
					phase_d     = PH_IDLE;
					probe_row_d = 2'd0;
				end else begin
					probe_row_d        = probe_row_q + 2'd1;
					result_d.row_drive = ~(4'b0001 << probe_row_d);
				end
			end
			PH_RELEASE: begin
				if (sample.column_sense == ALL_HIGH) begin
					if (load == 33'd0) begin
						report = 1'b1;
					end else begin
						settle_count_d = load[COUNT_WIDTH-1:0];
						phase_d        = PH_SETTLE;
					end
				end
			end
			default: begin
				settle_count_d = count_dec;
				if (count_dec == '0) begin
					report = 1'b1;
				end
			end
		endcase

		// Report the held key and drop back to idle
		if (report) begin
			result_d.key_valid = 1'b1;
			result_d.key_code  = held_code_q;
			phase_d            = PH_IDLE;
			probe_row_d        = 2'd0;
			settle_count_d     = '0;
		end
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_keys_q[0]    <= RESET_ROW0_KEYS;
			row_keys_q[1]    <= RESET_ROW1_KEYS;
			row_keys_q[2]    <= RESET_ROW2_KEYS;
			row_keys_q[3]    <= RESET_ROW3_KEYS;
			debounce_ticks_q <= RESET_DEBOUNCE;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ROW0_KEYS:      row_keys_q[0]    <= cfg_data;
				REG_ROW1_KEYS:      row_keys_q[1]    <= cfg_data;
				REG_ROW2_KEYS:      row_keys_q[2]    <= cfg_data;
				REG_ROW3_KEYS:      row_keys_q[3]    <= cfg_data;
				REG_DEBOUNCE_TICKS: debounce_ticks_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Update scan state on each accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			probe_row_q    <= 2'd0;
			held_code_q    <= 8'd0;
			settle_count_q <= '0;
		end else if (accept) begin
			phase_q        <= phase_d;
			probe_row_q    <= probe_row_d;
			held_code_q    <= held_code_d;
			settle_count_q <= settle_count_d;
		end
	end

	// Result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_d;
		end
	end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: matrix keypad scanner core check
// A virtual 4x4 keypad answers each row drive with a column request. A cycle
// model of the scanner predicts every result, and the results are checked in
// order. Random stalls, idle gaps and register settings run in later tests.
// ----------------------------------------------------------------------------
module testbench;
	import mks_pkg::*;

	localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_WIDTH) - 1;
	localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [2:0] REG_SPARE_LAST  = 3'd7;
	localparam int LONG_HOLD_CYCLES = 150;
	localparam int REPORT_LIMIT     = 10;
	localparam int TIMEOUT_NS       = 6_000_000;

	typedef enum logic [1:0] {
		SCAN_IDLE,
		SCAN_PROBE,
		SCAN_RELEASE,
		SCAN_SETTLE
	} scan_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        sample_valid = 1'b0;
	logic        sample_stall;
	mks_in_t     sample = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	mks_out_t    result;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// Scanner model: configuration copy and scan state
	logic [31:0]            row_keys [4];
	logic [15:0]            debounce_ticks;
	scan_phase_t            scan_phase;
	logic [1:0]             probe_row;
	logic [7:0]             held_code;
	logic [COUNT_WIDTH-1:0] settle_count;
	logic [3:0]             last_drive;

	// Virtual keypad and traffic knobs
	logic [15:0] key_down = '0;
	int          abort_pct = 0;
	int          noise_pct = 0;
	bit          sender_gaps = 1'b0;
	bit          receiver_gaps = 1'b0;
	bit          hold_request = 1'b0;

	mks_out_t pending_results [$];
	mks_out_t oldest_expected;
	int       fault_count = 0;

	matrix_keypad_scanner_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("testbench: FAIL");
		$finish;
	end

	// Advance the scan model by one sample request and return its result
	function automatic mks_out_t predict_scan(mks_in_t s);
		mks_out_t        r;
		logic [1:0]      col;
		longint unsigned load;
		bit              report;
		r = '0;
		report = 1'b0;
		case (scan_phase)
			SCAN_IDLE: begin
				if (s.abort) begin
					r.aborted = 1'b1;
				end else if (s.column_sense != ALL_HIGH) begin
					scan_phase = SCAN_PROBE;
					probe_row = 2'd0;
					r.row_drive = 4'b1110;
				end
			end
			SCAN_PROBE: begin
				if (s.column_sense != ALL_HIGH) begin
					col = 2'd0;
					for (int c = 3; c >= 0; c--)
						if (!s.column_sense[c])
							col = c[1:0];
					held_code = row_keys[probe_row][8*col +: 8];
					scan_phase = SCAN_RELEASE;
				end else if (probe_row == 2'd3) begin
					scan_phase = SCAN_IDLE;
					probe_row = 2'd0;
				end else begin
					probe_row = probe_row + 2'd1;
					r.row_drive = ~(4'b0001 << probe_row);
				end
			end
			SCAN_RELEASE: begin
				if (s.column_sense == ALL_HIGH) begin
					load = (debounce_ticks > COUNT_MAX) ? COUNT_MAX : debounce_ticks;
					if (load == 0) begin
						report = 1'b1;
					end else begin
						settle_count = load[COUNT_WIDTH-1:0];
						scan_phase = SCAN_SETTLE;
					end
				end
			end
			default: begin
				if (settle_count > 0)
					settle_count = settle_count - 1'b1;
				if (settle_count == 0)
					report = 1'b1;
			end
		endcase
		if (report) begin
			r.key_valid = 1'b1;
			r.key_code = held_code;
			scan_phase = SCAN_IDLE;
			probe_row = 2'd0;
			settle_count = '0;
		end
		last_drive = r.row_drive;
		return r;
	endfunction

	// Offer one sample request, with an optional idle gap ahead of it
	task automatic send_sample(mks_in_t s);
		int gap;
		if (sender_gaps && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 13);
			@(negedge clk);
			sample_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (sample_stall);
		pending_results.push_back(predict_scan(s));
	endtask

	// Build the column request from the keys held and the last row drive
	task automatic scan_tick(bit force_abort);
		mks_in_t s;
		s.column_sense = ALL_HIGH;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				if (key_down[4*r+c] && !last_drive[r])
					s.column_sense[c] = 1'b0;
		if ($urandom_range(0, 99) < noise_pct)
			s.column_sense = 4'($urandom_range(0, 15));
		s.abort = force_abort || ($urandom_range(0, 99) < abort_pct);
		send_sample(s);
	endtask

	// Drop valid and hold until every expected result has come back
	task automatic wait_all_results();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_ROW0_KEYS, REG_ROW1_KEYS, REG_ROW2_KEYS, REG_ROW3_KEYS:
				row_keys[idx[1:0]] = data;
			REG_DEBOUNCE_TICKS:
				debounce_ticks = data[15:0];
			default: ;
		endcase
	endtask

	task automatic write_maps(logic [31:0] m0, logic [31:0] m1, logic [31:0] m2,
			logic [31:0] m3);
		write_reg(REG_ROW0_KEYS, m0);
		write_reg(REG_ROW1_KEYS, m1);
		write_reg(REG_ROW2_KEYS, m2);
		write_reg(REG_ROW3_KEYS, m3);
	endtask

	// Hold keys until the scanner latches a code, then release and let it report
	task automatic press_keys(logic [15:0] keys, int hold_ticks);
		int guard;
		key_down = keys;
		guard = 0;
		while (scan_phase != SCAN_RELEASE && guard < 40) begin
			scan_tick(1'b0);
			guard++;
		end
		repeat (hold_ticks) scan_tick(1'b0);
		key_down = '0;
		while (scan_phase != SCAN_IDLE)
			scan_tick(1'b0);
	endtask

	// Tap keys briefly, then release and run the scan back to idle
	task automatic tap_keys(logic [15:0] keys, int ticks);
		key_down = keys;
		repeat (ticks) scan_tick(1'b0);
		key_down = '0;
		while (scan_phase != SCAN_IDLE)
			scan_tick(1'b0);
	endtask

	task automatic test_reset_values();
		abort_pct = 0;
		noise_pct = 0;
		press_keys(16'h0001 << $urandom_range(0, 15), 2);
		wait_all_results();
	endtask

	task automatic test_directed();
		mks_in_t s;
		write_maps(32'hFFFF_FFFF, 32'h0000_0000, 32'h8040_2010, 32'h5AA5_C33C);
		write_reg(REG_DEBOUNCE_TICKS, 32'd0);
		// Writes beyond the register list must change nothing
		for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
			write_reg(i[2:0], 32'hFFFF_FFFF);
		// Corner keys with zero debounce
		press_keys(16'h0001, 1);
		press_keys(16'h8000, 0);
		// Abort while idle wins over a low column, and with all columns high
		s.column_sense = ALL_LOW;
		s.abort = 1'b1;
		send_sample(s);
		s.column_sense = ALL_HIGH;
		send_sample(s);
		// No row found: the key is gone before the probe reaches it
		tap_keys(16'h1000, 1);
		// Several keys: lowest row, then lowest column wins
		press_keys(16'h01C0, 0);
		wait_all_results();
		// Abort outside idle is ignored through probe, release and settle
		write_reg(REG_DEBOUNCE_TICKS, 32'd1);
		key_down = 16'h0200;
		scan_tick(1'b0);
		while (scan_phase == SCAN_PROBE)
			scan_tick(1'b1);
		key_down = '0;
		while (scan_phase != SCAN_IDLE)
			scan_tick(1'b1);
		wait_all_results();
	endtask

	task automatic test_random_scans();
		logic [15:0] keys;
		int          pick;
		abort_pct = 10;
		noise_pct = 3;
		for (int k = 0; k < 6; k++) begin
			case (k)
				2: write_maps('0, '0, '0, '0);
				3: write_maps('1, '1, '1, '1);
				default: write_maps($urandom, $urandom, $urandom, $urandom);
			endcase
			case (k)
				0: write_reg(REG_DEBOUNCE_TICKS, 32'd0);
				1: write_reg(REG_DEBOUNCE_TICKS, 32'd1);
				default: write_reg(REG_DEBOUNCE_TICKS, $urandom_range(2, 12));
			endcase
			for (int n = 0; n < 5; n++) begin
				sender_gaps = ($urandom_range(0, 3) != 0);
				receiver_gaps = ($urandom_range(0, 3) != 0);
				pick = $urandom_range(0, 99);
				keys = 16'h0001 << $urandom_range(0, 15);
				if (pick < 15) begin
					tap_keys(keys, $urandom_range(1, 3));
				end else begin
					if (pick < 25)
						keys = keys | (16'h0001 << $urandom_range(0, 15));
					press_keys(keys, $urandom_range(0, 4));
				end
			end
			wait_all_results();
		end
	endtask

	task automatic test_backpressure();
		write_reg(REG_DEBOUNCE_TICKS, 32'd3);
		sender_gaps = 1'b0;
		// Stall the result side for a long stretch while requests keep coming
		hold_request = 1'b1;
		for (int n = 0; n < 4; n++)
			press_keys(16'h0001 << $urandom_range(0, 15), $urandom_range(0, 3));
		wait_all_results();
		sender_gaps = 1'b1;
		receiver_gaps = 1'b1;
		for (int n = 0; n < 4; n++)
			press_keys(16'h0001 << $urandom_range(0, 15), $urandom_range(0, 3));
		wait_all_results();
	endtask

	task automatic test_long_debounce();
		sender_gaps = 1'b0;
		receiver_gaps = 1'b0;
		abort_pct = 0;
		noise_pct = 0;
		write_maps($urandom, $urandom, $urandom, $urandom);
		write_reg(REG_DEBOUNCE_TICKS, 32'd200);
		press_keys(16'h0001 << $urandom_range(0, 15), 1);
		wait_all_results();
	endtask

	// Result side stalls: long hold on request, else random bursts
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request) begin
				result_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
				result_stall <= 1'b0;
			end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(negedge clk);
				result_stall <= 1'b0;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT)
					$display("%0t: unexpected result %p", $realtime, result);
			end else begin
				oldest_expected = pending_results.pop_front();
				if (result.row_drive !== oldest_expected.row_drive ||
						result.key_valid !== oldest_expected.key_valid ||
						result.key_code !== oldest_expected.key_code ||
						result.aborted !== oldest_expected.aborted) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT)
						$display("%0t: mismatch row_drive %h/%h key_valid %b/%b key_code %h/%h aborted %b/%b (exp/got)",
							$realtime, oldest_expected.row_drive, result.row_drive,
							oldest_expected.key_valid, result.key_valid,
							oldest_expected.key_code, result.key_code,
							oldest_expected.aborted, result.aborted);
				end
			end
		end
	end

	initial begin
		row_keys[0] = RESET_ROW0_KEYS;
		row_keys[1] = RESET_ROW1_KEYS;
		row_keys[2] = RESET_ROW2_KEYS;
		row_keys[3] = RESET_ROW3_KEYS;
		debounce_ticks = RESET_DEBOUNCE;
		scan_phase = SCAN_IDLE;
		probe_row = '0;
		held_code = '0;
		settle_count = '0;
		last_drive = ALL_LOW;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_directed();
		test_random_scans();
		test_backpressure();
		test_long_debounce();

		repeat (4) @(posedge clk);
		if (fault_count == 0 && pending_results.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

[sim.f]
sv/mks_pkg.sv
sv/matrix_keypad_scanner_core.sv
test/testbench.sv
